// ----- src/lpht_pkg.sv -----
`default_nettype none

package lpht_pkg;

	// Default sizes, used as defaults by the top level parameters
	localparam int SLOTS_DEF      = 256;
	localparam int KEY_BITS_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	// Entry limit register
	localparam int              LIMIT_W     = 8;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd192;

	// FNV-1a over eight key bytes, least significant byte first
	localparam int          HASH_BYTES = 8;
	localparam int          BYTE_IDX_W = 3;
	localparam logic [63:0] FNV_BASIS  = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] FNV_PRIME  = 64'h0000_0100_0000_01B3;

	// Operation codes
	localparam logic OP_PUT = 1'b0;
	localparam logic OP_GET = 1'b1;

	// Result status codes
	typedef enum logic [2:0] {
		RES_INSERTED  = 3'd0,
		RES_UPDATED   = 3'd1,
		RES_FOUND     = 3'd2,
		RES_NOT_FOUND = 3'd3,
		RES_FULL      = 3'd4,
		RES_INVALID   = 3'd5
	} status_t;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_CHECK,
		S_RESP
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    clr_wr;
		logic    load;
		logic    hash_step;
		logic    probe_init;
		logic    rd;
		logic    advance;
		logic    wr_key;
		logic    wr_val;
		logic    inc_count;
		logic    res_load;
		logic    res_found;
		status_t res_code;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic in_key_zero;
		logic is_get;
		logic hash_last;
		logic put_exhausted;
		logic get_bound;
		logic key_match;
		logic slot_empty;
		logic room;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- src/lpht_ctrl.sv -----
`default_nettype none

module lpht_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire lpht_pkg::sts_t sts,
	output lpht_pkg::cmd_t      cmd
);

	lpht_pkg::state_t  state_q, state_d;
	lpht_pkg::status_t res_q, res_d;
	logic              found_q, found_d;

	// State and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::S_CLEAR;
			res_q   <= lpht_pkg::RES_INVALID;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			found_q <= found_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		found_d  = found_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.res_code  = res_q;
		cmd.res_found = found_q;

		unique case (state_q)
			lpht_pkg::S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = lpht_pkg::S_IDLE;
				end
			end

			lpht_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					found_d  = 1'b0;
					if (sts.in_key_zero) begin
						res_d   = lpht_pkg::RES_INVALID;
						state_d = lpht_pkg::S_RESP;
					end else begin
						state_d = lpht_pkg::S_HASH;
					end
				end
			end

			// one key byte per cycle
			lpht_pkg::S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last) begin
					cmd.probe_init = 1'b1;
					state_d        = lpht_pkg::S_PROBE;
				end
			end

			// stop on probe bound, else read the slot
			lpht_pkg::S_PROBE: begin
				priority if (!sts.is_get && sts.put_exhausted) begin
					res_d   = lpht_pkg::RES_FULL;
					state_d = lpht_pkg::S_RESP;
				end else if (sts.is_get && sts.get_bound) begin
					res_d   = lpht_pkg::RES_NOT_FOUND;
					state_d = lpht_pkg::S_RESP;
				end else begin
					cmd.rd  = 1'b1;
					state_d = lpht_pkg::S_CHECK;
				end
			end

			lpht_pkg::S_CHECK: begin
				priority if (sts.key_match) begin
					state_d = lpht_pkg::S_RESP;
					if (sts.is_get) begin
						res_d   = lpht_pkg::RES_FOUND;
						found_d = 1'b1;
					end else begin
						cmd.wr_val = 1'b1;
						res_d      = lpht_pkg::RES_UPDATED;
					end
				end else if (sts.slot_empty) begin
					state_d = lpht_pkg::S_RESP;
					priority if (sts.is_get) begin
						res_d = lpht_pkg::RES_NOT_FOUND;
					end else if (sts.room) begin
						cmd.wr_key    = 1'b1;
						cmd.wr_val    = 1'b1;
						cmd.inc_count = 1'b1;
						res_d         = lpht_pkg::RES_INSERTED;
					end else begin
						res_d = lpht_pkg::RES_FULL;
					end
				end else begin
					cmd.advance = 1'b1;
					state_d     = lpht_pkg::S_PROBE;
				end
			end

			// wait for the output register to free up
			lpht_pkg::S_RESP: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = lpht_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = lpht_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/lpht_datapath.sv -----
`default_nettype none

module lpht_datapath #(
	parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
	parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF,
	localparam int CNT_W     = $clog2(SLOTS + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lpht_pkg::cmd_t               cmd,
	output lpht_pkg::sts_t                    sts,
	input  wire logic                         operation,
	input  wire logic [KEY_BITS-1:0]          key,
	input  wire logic [VALUE_BITS-1:0]        value,
	input  wire logic                         cfg_valid,
	input  wire logic [lpht_pkg::LIMIT_W-1:0] cfg_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [2:0]                        status,
	output logic [VALUE_BITS-1:0]             value_out,
	output logic [CNT_W-1:0]                  entry_count
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int LIM_W  = (CNT_W > lpht_pkg::LIMIT_W) ? CNT_W : lpht_pkg::LIMIT_W;

	// Captured item
	logic                  op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// Hash and probe registers
	logic [SLOT_W-1:0]               h_q;
	logic [lpht_pkg::BYTE_IDX_W-1:0] byte_q;
	logic [SLOT_W-1:0]               idx_q;
	logic [CNT_W-1:0]                n_q;
	logic [CNT_W-1:0]                count_q;
	logic [lpht_pkg::LIMIT_W-1:0]    limit_q;
	logic [SLOT_W-1:0]               clr_q;

	// Slot stores
	logic [KEY_BITS-1:0]   key_mem [SLOTS];
	logic [VALUE_BITS-1:0] val_mem [SLOTS];
	logic [KEY_BITS-1:0]   rkey_q;
	logic [VALUE_BITS-1:0] rval_q;

	// Result register
	logic                    out_valid_q;
	lpht_pkg::status_t       status_q;
	logic [VALUE_BITS-1:0]   vout_q;
	logic [CNT_W-1:0]        cnt_q;

	logic [63:0]       key_ext;
	logic [7:0]        key_byte;
	logic [SLOT_W-1:0] hx;
	logic [SLOT_W-1:0] h_next;
	logic [SLOT_W:0]   h_ext;
	logic [SLOT_W-1:0] home;
	logic [SLOT_W-1:0] idx_next;

	// FNV-1a step on the low slot bits only; the high bits never reach them
	always_comb begin
		key_ext  = 64'(key_q);
		key_byte = key_ext[{byte_q, 3'b000} +: 8];
		hx       = h_q ^ SLOT_W'(key_byte);
		h_next   = SLOT_W'(hx * SLOT_W'(lpht_pkg::FNV_PRIME));
		h_ext    = {1'b0, h_next};
		// fold into range when the slot count is not a power of two
		if (h_ext >= (SLOT_W + 1)'(SLOTS)) begin
			home = SLOT_W'(h_ext - (SLOT_W + 1)'(SLOTS));
		end else begin
			home = h_next;
		end
		idx_next = (idx_q == SLOT_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			key_q <= key;
			val_q <= value;
		end
	end

	// Hash, probe, count, limit and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= '0;
			byte_q  <= '0;
			idx_q   <= '0;
			n_q     <= '0;
			count_q <= '0;
			limit_q <= lpht_pkg::LIMIT_RESET;
			clr_q   <= '0;
		end else begin
			if (cmd.load) begin
				h_q    <= SLOT_W'(lpht_pkg::FNV_BASIS);
				byte_q <= '0;
			end else if (cmd.hash_step) begin
				h_q    <= h_next;
				byte_q <= byte_q + 1'b1;
			end
			if (cmd.probe_init) begin
				idx_q <= home;
				n_q   <= '0;
			end else if (cmd.advance) begin
				idx_q <= idx_next;
				n_q   <= n_q + 1'b1;
			end
			if (cmd.inc_count) begin
				count_q <= count_q + 1'b1;
			end
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Slot memories, registered read
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			key_mem[clr_q] <= '0;
		end else if (cmd.wr_key) begin
			key_mem[idx_q] <= key_q;
		end
		if (cmd.wr_val) begin
			val_mem[idx_q] <= val_q;
		end
		if (cmd.rd) begin
			rkey_q <= key_mem[idx_q];
			rval_q <= val_mem[idx_q];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_code;
			vout_q   <= cmd.res_found ? rval_q : '0;
			cnt_q    <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = 3'(status_q);
	assign value_out   = vout_q;
	assign entry_count = cnt_q;

	// Status to the controller
	always_comb begin
		sts.clr_last      = (clr_q == SLOT_W'(SLOTS - 1));
		sts.in_key_zero   = (key == '0);
		sts.is_get        = (op_q == lpht_pkg::OP_GET);
		sts.hash_last     = (byte_q == lpht_pkg::BYTE_IDX_W'(lpht_pkg::HASH_BYTES - 1));
		sts.put_exhausted = (n_q == CNT_W'(SLOTS));
		sts.get_bound     = (n_q >= count_q);
		sts.key_match     = (rkey_q == key_q);
		sts.slot_empty    = (rkey_q == '0);
		sts.room          = (LIM_W'(count_q) < LIM_W'(limit_q)) &&
		                    (count_q < CNT_W'(SLOTS));
		sts.out_free      = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

// ----- src/linear_probe_hash_table_top.sv -----
// A key of zero goes straight to the result state after acceptance; any other item is
//   hashed over eight key bytes, then read and checked slot by slot, and a probe bound
//   that ends the search adds one more pass through the probe state.
// Throughput: one item at a time; the next is taken the cycle after the result is
//   registered, while that result may still wait at the output.
// Reset: asynchronous; the key store is swept to empty slot by slot after reset,
//   in_ready low meanwhile; limit writes are taken at all times.
`default_nettype none

module linear_probe_hash_table_top #(
	parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
	parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF,
	localparam int CNT_W     = $clog2(SLOTS + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         operation,
	input  wire logic [KEY_BITS-1:0]          key,
	input  wire logic [VALUE_BITS-1:0]        value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [2:0]                        status,
	output logic [VALUE_BITS-1:0]             value_out,
	output logic [CNT_W-1:0]                  entry_count,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [lpht_pkg::LIMIT_W-1:0] cfg_data
);

	lpht_pkg::cmd_t cmd;
	lpht_pkg::sts_t sts;

	// limit register is always writable
	assign cfg_ready = 1'b1;

	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpht_datapath #(
		.SLOTS      (SLOTS),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.key         (key),
		.value       (value),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.value_out   (value_out),
		.entry_count (entry_count)
	);

	// A beat with a real key keeps the input side busy next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && key != '0) |=> !in_ready)
		else $error("input ready right after a keyed beat");

	// Only a found result carries a value
	a_value_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != 3'(lpht_pkg::RES_FOUND)) |-> value_out == '0)
		else $error("value on a result that is not found");

	// A new entry is stored only with room under the limit
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.inc_count |-> (sts.room && sts.slot_empty && !sts.is_get))
		else $error("entry stored without room");

	// An inserted result never reports an empty table
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == 3'(lpht_pkg::RES_INSERTED)) |-> entry_count != '0)
		else $error("insert reported with zero entries");

endmodule

`default_nettype wire
